@@ rtl/core/sdta_pkg.sv @@
// package for the signed decimal to ascii converter: types and constants
`default_nettype none

package sdta_pkg;

    // field widths
    localparam int unsigned VALUE_W   = 16;
    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned DIGIT_W   = 4;
    localparam int unsigned NUM_DIGITS = 5;
    localparam int unsigned BCD_W     = NUM_DIGITS * DIGIT_W;
    localparam int unsigned BIT_CNT_W = $clog2(VALUE_W);
    localparam int unsigned DIG_CNT_W = $clog2(NUM_DIGITS + 1);

    // ascii codes
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;

    // double dabble correction threshold and offset
    localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
    localparam logic [DIGIT_W-1:0] DABBLE_ADD   = 4'd3;

    // converter sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } state_t;

endpackage : sdta_pkg

`default_nettype wire

@@ rtl/core/signed_decimal_to_ascii.sv @@
// signed 16-bit integer to decimal ascii text, bit-serial double dabble
//
//  channel | ports                           | direction
//  --------+---------------------------------+----------
//  input   | s_valid s_ready s_value[15:0]   | in
//  result  | m_valid m_ready m_char_code[7:0] m_last_char | out
//
// a request is loaded, its 16 magnitude bits are shifted through the serial
// converter, leading zero digits are dropped one at a time (the units digit
// always stays), and the sign and digits then go out as one character per
// cycle (1 to 6 characters) while the result side does not stall.
// aresetn is synchronous and active low and clears the sequencer and m_valid.
// a stalled result holds in the output register; the sequencer waits on it.
// s_ready is high only while the converter is idle.
`default_nettype none

module signed_decimal_to_ascii (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_valid,
    output logic                              s_ready,
    input  wire  signed [sdta_pkg::VALUE_W-1:0] s_value,
    output logic                              m_valid,
    input  wire                               m_ready,
    output logic [sdta_pkg::CHAR_W-1:0]       m_char_code,
    output logic                              m_last_char
);

    import sdta_pkg::*;

    state_t                 state_reg, state_next;
    logic [VALUE_W-1:0]     mag_reg, mag_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [DIG_CNT_W-1:0]   dig_cnt_reg, dig_cnt_next;
    logic                   sign_reg, sign_next;
    logic                   m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]      m_char_reg, m_char_next;
    logic                   m_last_reg, m_last_next;

    logic                   in_take;
    logic                   out_free;
    logic [DIGIT_W-1:0]     top_digit;
    logic [BCD_W-1:0]       bcd_fixed;
    logic [VALUE_W-1:0]     abs_value;
    logic                   last_digit;

    assign in_take    = s_valid && (state_reg == ST_IDLE);
    assign out_free   = !m_valid_reg || m_ready;
    assign top_digit  = bcd_reg[BCD_W-1 -: DIGIT_W];
    assign last_digit = (dig_cnt_reg == DIG_CNT_W'(1));

    // magnitude fits 16 bits unsigned, -32768 maps to 32768
    assign abs_value = s_value[VALUE_W-1] ? (~s_value + VALUE_W'(1)) : s_value;

    // add-3 correction on every bcd digit before the shift
    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (bcd_reg[d*DIGIT_W +: DIGIT_W] >= DABBLE_LIMIT) begin
                bcd_fixed[d*DIGIT_W +: DIGIT_W] = bcd_reg[d*DIGIT_W +: DIGIT_W] + DABBLE_ADD;
            end else begin
                bcd_fixed[d*DIGIT_W +: DIGIT_W] = bcd_reg[d*DIGIT_W +: DIGIT_W];
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_take) begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                if (bit_cnt_reg == '0) begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (top_digit != '0 || last_digit) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free && !sign_reg && last_digit) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and output register
    always_comb begin
        mag_next     = mag_reg;
        bcd_next     = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        sign_next    = sign_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_take) begin
                    mag_next     = abs_value;
                    bcd_next     = '0;
                    bit_cnt_next = BIT_CNT_W'(VALUE_W - 1);
                    dig_cnt_next = DIG_CNT_W'(NUM_DIGITS);
                    sign_next    = s_value[VALUE_W-1];
                end
            end
            ST_CONV: begin
                {bcd_next, mag_next} = {bcd_fixed[BCD_W-2:0], mag_reg, 1'b0};
                bit_cnt_next         = bit_cnt_reg - BIT_CNT_W'(1);
            end
            ST_SKIP: begin
                // drop a leading zero digit, always keep the units digit
                if (top_digit == '0 && !last_digit) begin
                    bcd_next     = {bcd_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    dig_cnt_next = dig_cnt_reg - DIG_CNT_W'(1);
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (sign_reg) begin
                        m_char_next = CHAR_MINUS;
                        m_last_next = 1'b0;
                        sign_next   = 1'b0;
                    end else begin
                        m_char_next  = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
                        m_last_next  = last_digit;
                        bcd_next     = {bcd_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                        dig_cnt_next = dig_cnt_reg - DIG_CNT_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        mag_reg     <= mag_next;
        bcd_reg     <= bcd_next;
        bit_cnt_reg <= bit_cnt_next;
        dig_cnt_reg <= dig_cnt_next;
        sign_reg    <= sign_next;
        m_char_reg  <= m_char_next;
        m_last_reg  <= m_last_next;
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_char_code = m_char_reg;
    assign m_last_char = m_last_reg;

endmodule : signed_decimal_to_ascii

`default_nettype wire

@@ test/signed_decimal_to_ascii_test.sv @@
// testbench for the signed decimal to ascii converter: scoreboard, stimulus and checks
`default_nettype none

module signed_decimal_to_ascii_test;

    import sdta_pkg::*;

    // one expected character of a value's decimal text
    typedef struct {
        logic [CHAR_W-1:0] code;
        logic              last;
    } text_char_t;

    // keeps the decimal text still owed by the block and checks characters against it
    class digit_text_board;
        text_char_t pending_chars[$];
        int unsigned mismatches;
        int unsigned chars_seen;

        function new();
            mismatches = 0;
            chars_seen = 0;
        endfunction

        // spell out an accepted value as sign and digits, most significant first
        function void note_value(logic signed [VALUE_W-1:0] value);
            logic [VALUE_W:0] magnitude;
            logic [3:0]       digits [NUM_DIGITS];
            int               num_digits;
            text_char_t       ch;
            magnitude  = value[VALUE_W-1] ? (17'h10000 - {1'b0, value}) : {1'b0, value};
            num_digits = 0;
            // zero has no digits from the loop below, so it is a single '0'
            if (magnitude == 0) begin
                ch.code = CHAR_ZERO;
                ch.last = 1'b1;
                pending_chars.push_back(ch);
                return;
            end
            while (magnitude != 0) begin
                digits[num_digits] = 4'(magnitude % 10);
                magnitude          = magnitude / 10;
                num_digits++;
            end
            if (value[VALUE_W-1]) begin
                ch.code = CHAR_MINUS;
                ch.last = 1'b0;
                pending_chars.push_back(ch);
            end
            for (int i = num_digits - 1; i >= 0; i--) begin
                ch.code = CHAR_ZERO + CHAR_W'(digits[i]);
                ch.last = (i == 0);
                pending_chars.push_back(ch);
            end
        endfunction

        // compare one accepted character with the oldest one owed
        function void check_char(logic [CHAR_W-1:0] code, logic last);
            text_char_t want;
            chars_seen++;
            if (pending_chars.size() == 0) begin
                $error("unexpected character: char_code %0d last_char %0b", code, last);
                mismatches++;
                return;
            end
            want = pending_chars.pop_front();
            if (code !== want.code) begin
                $error("char_code: expected %0d, got %0d", want.code, code);
                mismatches++;
            end
            if (last !== want.last) begin
                $error("last_char: expected %0b, got %0b", want.last, last);
                mismatches++;
            end
        endfunction
    endclass

    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       s_valid   = 1'b0;
    logic                       s_ready;
    logic signed [VALUE_W-1:0]  s_value   = '0;
    logic                       m_valid;
    logic                       m_ready   = 1'b0;
    logic [CHAR_W-1:0]          m_char_code;
    logic                       m_last_char;

    digit_text_board board = new();

    int unsigned values_sent    = 0;
    int unsigned negatives_sent = 0;
    int unsigned burst_left     = 0;

    // receiver stall pattern state
    int unsigned ready_mode      = 0;
    int unsigned ready_mode_left = 0;
    int unsigned ready_phase     = 0;

    signed_decimal_to_ascii u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_char_code (m_char_code),
        .m_last_char (m_last_char)
    );

    // clock
    always #2 aclk = ~aclk;

    // hard limit on the run
    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    // present one request and hold it until the converter takes it
    task automatic send_value(input logic signed [VALUE_W-1:0] value);
        s_valid <= 1'b1;
        s_value <= value;
        do @(posedge aclk); while (s_ready !== 1'b1);
        board.note_value(value);
        values_sent++;
        if (value < 0) negatives_sent++;
    endtask

    // send in bursts of random length with random gaps between them
    task automatic feed_value(input logic signed [VALUE_W-1:0] value);
        int unsigned gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                s_value <= VALUE_W'($urandom_range(0, 65535));
                repeat (gap) @(posedge aclk);
            end
        end
        send_value(value);
        burst_left--;
    endtask

    // random value, mostly spread evenly over the digit counts
    function automatic logic signed [VALUE_W-1:0] pick_value();
        int num_digits;
        int lowest;
        int highest;
        int magnitude;
        if ($urandom_range(0, 7) == 0) begin
            return VALUE_W'($urandom_range(0, 65535));
        end
        num_digits = $urandom_range(1, NUM_DIGITS);
        lowest     = (num_digits == 1) ? 0 : 10 ** (num_digits - 1);
        highest    = (10 ** num_digits) - 1;
        if (highest > 32767) highest = 32767;
        magnitude  = $urandom_range(highest, lowest);
        return $urandom_range(0, 1) ? VALUE_W'(-magnitude) : VALUE_W'(magnitude);
    endfunction

    // result side: check accepted characters, then pick the next ready level
    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            board.check_char(m_char_code, m_last_char);
        end
        if (ready_mode_left == 0) begin
            ready_mode      = $urandom_range(0, 3);
            ready_mode_left = $urandom_range(32, 96);
        end else begin
            ready_mode_left--;
        end
        ready_phase++;
        case (ready_mode)
            0: begin
                m_ready <= 1'b1;
            end
            1: begin
                m_ready <= 1'($urandom_range(0, 1));
            end
            2: begin
                m_ready <= ($urandom_range(0, 7) == 0);
            end
            default: begin
                m_ready <= ready_phase[0];
            end
        endcase
    end

    // stimulus and end of run
    initial begin
        int corner_values [22] = '{
            0, 1, -1, 5, 9, 10, -10, 99, 100, -999, 1000, 9999,
            10000, -10000, 32767, -32767, -32768, 12345, -21846, 21845, 30000, -7
        };
        int unsigned wait_cycles;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // corners: zero, single digits, digit-count edges, both extremes, bit patterns
        foreach (corner_values[i]) begin
            feed_value(VALUE_W'(corner_values[i]));
        end

        // random part
        repeat (200) begin
            feed_value(pick_value());
        end
        s_valid <= 1'b0;

        // drain what the block still owes, then a short quiet stretch
        wait_cycles = 0;
        while (board.pending_chars.size() != 0 && wait_cycles < 20000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (40) @(posedge aclk);

        $display("converted %0d values (%0d negative) into %0d checked characters",
                 values_sent, negatives_sent, board.chars_seen);
        $display("%0d characters still owed, %0d mismatches",
                 board.pending_chars.size(), board.mismatches);
        if (board.mismatches == 0 && board.pending_chars.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule : signed_decimal_to_ascii_test

`default_nettype wire

@@ signed_decimal_to_ascii.f @@
rtl/core/sdta_pkg.sv
rtl/core/signed_decimal_to_ascii.sv
test/signed_decimal_to_ascii_test.sv
